[src/nlrf_pkg.sv]
// Shared types, codes and helper functions for the node link receive filter and timers unit.
// Has no dependencies; every other file imports it.
package nlrf_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned MAX_RESULTS = 3;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_PACKET = 2'd1;
  localparam logic [1:0] CMD_ARM    = 2'd2;
  localparam logic [1:0] CMD_DISARM = 2'd3;

  localparam logic [1:0] KIND_OTHER      = 2'd0;
  localparam logic [1:0] KIND_CONFIG     = 2'd1;
  localparam logic [1:0] KIND_COMMAND    = 2'd2;
  localparam logic [1:0] KIND_SET_CONFIG = 2'd3;

  localparam logic [2:0] ACT_TELEMETRY = 3'd0;
  localparam logic [2:0] ACT_CONFIG    = 3'd1;
  localparam logic [2:0] ACT_ACK       = 3'd2;
  localparam logic [2:0] ACT_WATCHDOG  = 3'd3;
  localparam logic [2:0] ACT_CLOCK     = 3'd4;

  localparam logic [2:0] REG_OWN_ADDRESS     = 3'd0;
  localparam logic [2:0] REG_TEL_INTERVAL    = 3'd1;
  localparam logic [2:0] REG_TEL_JITTER      = 3'd2;
  localparam logic [2:0] REG_CFG_INTERVAL    = 3'd3;
  localparam logic [2:0] REG_CFG_JITTER      = 3'd4;
  localparam logic [2:0] REG_CONTACT_TIMEOUT = 3'd5;

  localparam logic [47:0] ADDR_BROADCAST = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] TEL_INTERVAL_RST = 32'd60000;
  localparam logic [31:0] CFG_INTERVAL_RST = 32'd3600000;
  localparam logic [31:0] CONTACT_TIMEOUT_RST = 32'd300000;

  typedef struct packed {
    logic [47:0] own_address;
    logic [31:0] tel_interval;
    logic [14:0] tel_jitter;
    logic [31:0] cfg_interval;
    logic [14:0] cfg_jitter;
    logic [31:0] contact_timeout;
  } cfg_regs_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [47:0]        dest_address;
    logic               sender_is_hub;
    logic [1:0]         msg_kind;
    logic [15:0]        rx_id;
    logic [31:0]        rx_epoch;
    logic [7:0]         handler_status;
    logic signed [15:0] telemetry_offset;
    logic signed [15:0] config_offset;
  } item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] ack_id;
    logic [7:0]  ack_status;
    logic [31:0] clock_epoch;
  } result_t;

  typedef struct packed {
    logic [1:0]                    cnt;
    result_t [MAX_RESULTS-1:0]     res;
  } bundle_t;

  function automatic logic signed [15:0] clamp_off(input logic signed [15:0] off,
                                                   input logic [14:0] jit);
    logic signed [15:0] j;
    j = signed'({1'b0, jit});
    if (off > j) begin
      return j;
    end else if (off < -j) begin
      return -j;
    end
    return off;
  endfunction

  function automatic logic id_newer(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    return (d != 16'd0) && !d[15];
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic period_due(input logic [31:0] elapsed, input logic [31:0] base,
                                      input logic signed [15:0] off, input logic [14:0] jit);
    logic signed [15:0] c;
    logic signed [33:0] thr;
    logic signed [33:0] el;
    c   = clamp_off(off, jit);
    thr = signed'({2'b00, base}) + 34'(c);
    el  = signed'({2'b00, elapsed});
    return el > thr;
  endfunction

endpackage

[src/nlrf_core.sv]
// Per-item decision logic and link state: timers, receive filter, dedup and result bundling.
// Depends on nlrf_pkg.
module nlrf_core
  import nlrf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_regs_t cfg,
  input  logic      item_valid,
  input  item_t     item,
  input  logic      q_full,
  output logic      item_fire,
  output logic      push,
  output bundle_t   push_bundle
);

  logic [31:0]        tel_el_r, tel_el_nxt;
  logic [31:0]        cfg_el_r, cfg_el_nxt;
  logic [31:0]        cnt_el_r, cnt_el_nxt;
  logic signed [15:0] tel_off_r, tel_off_nxt;
  logic signed [15:0] cfg_off_r, cfg_off_nxt;
  logic               wd_armed_r, wd_armed_nxt;
  logic               ann_seen_r, ann_seen_nxt;
  logic [15:0]        ann_id_r, ann_id_nxt;
  logic [15:0]        acc_id_r, acc_id_nxt;

  logic [31:0] tel_inc, cfg_inc, cnt_inc;
  logic        addr_hit, announce, accepted;
  logic [3:0]  cand_v;
  result_t [3:0] cand_r;
  logic [1:0]  n;
  bundle_t     bundle;

  assign item_fire = item_valid && !q_full;

  always_comb begin
    tel_inc = sat_inc(tel_el_r);
    cfg_inc = sat_inc(cfg_el_r);
    cnt_inc = sat_inc(cnt_el_r);
    addr_hit = (item.dest_address == cfg.own_address) || (item.dest_address == ADDR_BROADCAST);
    announce = item.sender_is_hub && (item.msg_kind == KIND_CONFIG);
    accepted = announce || id_newer(item.rx_id, acc_id_r);

    tel_el_nxt   = tel_el_r;
    cfg_el_nxt   = cfg_el_r;
    cnt_el_nxt   = cnt_el_r;
    tel_off_nxt  = tel_off_r;
    cfg_off_nxt  = cfg_off_r;
    wd_armed_nxt = wd_armed_r;
    ann_seen_nxt = ann_seen_r;
    ann_id_nxt   = ann_id_r;
    acc_id_nxt   = acc_id_r;
    cand_v       = '0;
    cand_r       = '0;

    unique case (item.cmd)
      CMD_TICK: begin
        tel_el_nxt = tel_inc;
        cfg_el_nxt = cfg_inc;
        cnt_el_nxt = cnt_inc;
        if (period_due(tel_inc, cfg.tel_interval, tel_off_r, cfg.tel_jitter)) begin
          tel_el_nxt  = '0;
          tel_off_nxt = clamp_off(item.telemetry_offset, cfg.tel_jitter);
          cand_v[0]   = 1'b1;
          cand_r[0].action = ACT_TELEMETRY;
        end
        if (period_due(cfg_inc, cfg.cfg_interval, cfg_off_r, cfg.cfg_jitter)) begin
          cfg_el_nxt  = '0;
          cfg_off_nxt = clamp_off(item.config_offset, cfg.cfg_jitter);
          cand_v[1]   = 1'b1;
          cand_r[1].action = ACT_CONFIG;
        end
        if (wd_armed_r && (cnt_inc > cfg.contact_timeout)) begin
          wd_armed_nxt = 1'b0;
          cand_v[2]    = 1'b1;
          cand_r[2].action = ACT_WATCHDOG;
        end
      end
      CMD_PACKET: begin
        if (addr_hit) begin
          if (announce) begin
            ann_seen_nxt = 1'b1;
            ann_id_nxt   = item.rx_id;
            cand_v[0]    = ann_seen_r && !id_newer(item.rx_id, ann_id_r);
            cand_r[0].action = ACT_CONFIG;
            cand_v[1]    = (item.rx_epoch != 32'd0);
            cand_r[1].action = ACT_CLOCK;
            cand_r[1].clock_epoch = item.rx_epoch;
          end
          if (accepted) begin
            acc_id_nxt = item.rx_id;
            cnt_el_nxt = '0;
            cand_v[2]  = (item.msg_kind == KIND_COMMAND) ||
                         (item.msg_kind == KIND_SET_CONFIG);
            cand_r[2].action     = ACT_ACK;
            cand_r[2].ack_id     = item.rx_id;
            cand_r[2].ack_status = item.handler_status;
            cand_v[3]  = (item.msg_kind == KIND_SET_CONFIG) &&
                         (item.handler_status == 8'd0);
            cand_r[3].action = ACT_CONFIG;
          end
        end
      end
      CMD_ARM: begin
        wd_armed_nxt = 1'b1;
      end
      CMD_DISARM: begin
        wd_armed_nxt = 1'b0;
      end
      default: begin
        wd_armed_nxt = wd_armed_r;
      end
    endcase
  end

  always_comb begin
    n      = '0;
    bundle = '0;
    for (int k = 0; k < 4; k++) begin
      if (cand_v[k] && (n != 2'd3)) begin
        bundle.res[n] = cand_r[k];
        n = n + 2'd1;
      end
    end
    bundle.cnt = n;
  end

  assign push        = item_fire && (bundle.cnt != 2'd0);
  assign push_bundle = bundle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tel_el_r   <= '0;
      cfg_el_r   <= '0;
      cnt_el_r   <= '0;
      tel_off_r  <= '0;
      cfg_off_r  <= '0;
      wd_armed_r <= 1'b0;
      ann_seen_r <= 1'b0;
      ann_id_r   <= '0;
      acc_id_r   <= '0;
    end else if (item_fire) begin
      tel_el_r   <= tel_el_nxt;
      cfg_el_r   <= cfg_el_nxt;
      cnt_el_r   <= cnt_el_nxt;
      tel_off_r  <= tel_off_nxt;
      cfg_off_r  <= cfg_off_nxt;
      wd_armed_r <= wd_armed_nxt;
      ann_seen_r <= ann_seen_nxt;
      ann_id_r   <= ann_id_nxt;
      acc_id_r   <= acc_id_nxt;
    end
  end

  a_miss_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    item_fire && item.cmd == CMD_PACKET && !addr_hit
    |=> $stable(acc_id_r) && $stable(ann_id_r) && $stable(cnt_el_r))
    else $error("packet for another address changed link state");

  a_wd_fire_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    push && item.cmd == CMD_TICK && wd_armed_r && (cnt_inc > cfg.contact_timeout)
    |=> !wd_armed_r)
    else $error("watchdog did not disarm after firing");

  a_accept_clears_contact: assert property (@(posedge clk) disable iff (!rst_n)
    item_fire && item.cmd == CMD_PACKET && addr_hit && accepted
    |=> cnt_el_r == 32'd0 && acc_id_r == $past(item.rx_id))
    else $error("accepted packet did not refresh contact state");

endmodule

[src/nlrf_rq.sv]
// Result queue: holds result bundles and hands them out one beat at a time with last_of_run.
// Depends on nlrf_pkg.
module nlrf_rq
  import nlrf_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  bundle_t     push_bundle,
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic [15:0] out_ack_id,
  output logic [7:0]  out_ack_status,
  output logic [31:0] out_clock_epoch,
  output logic        out_last_of_run
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bundle_t              fifo_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [1:0]           idx_r;
  bundle_t              head;
  result_t              cur;
  logic                 beat, pop;

  assign head      = fifo_r[rd_ptr_r];
  assign cur       = head.res[idx_r];
  assign out_valid = (cnt_r != '0);
  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign beat      = out_valid && !out_stall;
  assign out_last_of_run = (idx_r == head.cnt - 2'd1);
  assign pop       = beat && out_last_of_run;

  assign out_action      = cur.action;
  assign out_ack_id      = cur.ack_id;
  assign out_ack_status  = cur.ack_status;
  assign out_clock_epoch = cur.clock_epoch;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      idx_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
        idx_r    <= '0;
      end else if (beat) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("result queue overflow");

  a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (head.cnt != 2'd0) && (idx_r < head.cnt))
    else $error("result queue head holds no result at the current slot");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    beat && !out_last_of_run |=> out_valid && idx_r == $past(idx_r) + 2'd1)
    else $error("result run broken before its last beat");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("bundle written into a full queue");

endmodule

[src/node_link_receive_filter_and_timers_unit.sv]
// Top level of the node link receive filter and timers unit: config registers, input register,
// decision core and result queue. Depends on nlrf_pkg, nlrf_core and nlrf_rq.
//
//   Port group | Direction | Handshake           | Beat contents
//   in_*       | input     | in_valid / in_stall | one tick, packet, arm or disarm item
//   out_*      | output    | out_valid/out_stall | one result with last_of_run on the final one
//   cfg_*      | input     | cfg_valid/cfg_ready | register index and write data
//
// An accepted item waits in the input register until the result queue has room; it is then
// decided, its results queued. One item enters per cycle while in_stall is low; an item
// with k results holds the result port for k beats; the port thus sets the multi-result rate.
// Reset is synchronous and active low and clears all timers, ids and flags.
// An output stall backs up the result queue, which then stalls the input side.
module node_link_receive_filter_and_timers_unit
  import nlrf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [47:0]        in_dest_address,
  input  logic               in_sender_is_hub,
  input  logic [1:0]         in_msg_kind,
  input  logic [15:0]        in_rx_id,
  input  logic [31:0]        in_rx_epoch,
  input  logic [7:0]         in_handler_status,
  input  logic signed [15:0] in_telemetry_offset,
  input  logic signed [15:0] in_config_offset,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_action,
  output logic [15:0]        out_ack_id,
  output logic [7:0]         out_ack_status,
  output logic [31:0]        out_clock_epoch,
  output logic               out_last_of_run,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  cfg_regs_t cfg_r;
  logic      s1_valid_r;
  item_t     s1_item_r;
  logic      q_full, item_fire, push;
  bundle_t   push_bundle;
  logic      in_beat;

  assign cfg_ready = 1'b1;
  assign in_stall  = s1_valid_r && q_full;
  assign in_beat   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_address     <= '0;
      cfg_r.tel_interval    <= TEL_INTERVAL_RST;
      cfg_r.tel_jitter      <= '0;
      cfg_r.cfg_interval    <= CFG_INTERVAL_RST;
      cfg_r.cfg_jitter      <= '0;
      cfg_r.contact_timeout <= CONTACT_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OWN_ADDRESS:     cfg_r.own_address     <= cfg_data;
        REG_TEL_INTERVAL:    cfg_r.tel_interval    <= cfg_data[31:0];
        REG_TEL_JITTER:      cfg_r.tel_jitter      <= cfg_data[14:0];
        REG_CFG_INTERVAL:    cfg_r.cfg_interval    <= cfg_data[31:0];
        REG_CFG_JITTER:      cfg_r.cfg_jitter      <= cfg_data[14:0];
        REG_CONTACT_TIMEOUT: cfg_r.contact_timeout <= cfg_data[31:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_beat) begin
      s1_valid_r <= 1'b1;
    end else if (item_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_item_r.cmd              <= in_cmd;
      s1_item_r.dest_address     <= in_dest_address;
      s1_item_r.sender_is_hub    <= in_sender_is_hub;
      s1_item_r.msg_kind         <= in_msg_kind;
      s1_item_r.rx_id            <= in_rx_id;
      s1_item_r.rx_epoch         <= in_rx_epoch;
      s1_item_r.handler_status   <= in_handler_status;
      s1_item_r.telemetry_offset <= in_telemetry_offset;
      s1_item_r.config_offset    <= in_config_offset;
    end
  end

  nlrf_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .item_valid  (s1_valid_r),
    .item        (s1_item_r),
    .q_full      (q_full),
    .item_fire   (item_fire),
    .push        (push),
    .push_bundle (push_bundle)
  );

  nlrf_rq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_rq (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .push_bundle     (push_bundle),
    .full            (q_full),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_action      (out_action),
    .out_ack_id      (out_ack_id),
    .out_ack_status  (out_ack_status),
    .out_clock_epoch (out_clock_epoch),
    .out_last_of_run (out_last_of_run)
  );

endmodule
